### sv/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types, register indexes and state encodings for the CSV tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  // Dialect limits and widths
  localparam int unsigned MAX_DELIMITER_BYTES = 4;
  localparam int unsigned TOK_STATE_COUNT     = 19;
  localparam int unsigned STATE_CODE_W        = 5;
  localparam int unsigned CFG_INDEX_W         = 3;
  localparam int unsigned CFG_DATA_W          = 32;
  localparam int unsigned DLEN_W              = 3;

  // Special characters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_BYTES = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELIM_LEN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMENT     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRLF        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRICT      = 3'd6;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_DELIM_BYTES = 32'd44;
  localparam logic [DLEN_W-1:0]     RST_DELIM_LEN   = 3'd1;
  localparam logic [7:0]            RST_QUOTE       = 8'd34;
  localparam logic [7:0]            RST_ESCAPE      = 8'd0;
  localparam logic [7:0]            RST_COMMENT     = 8'd0;
  localparam logic                  RST_CRLF        = 1'b0;
  localparam logic                  RST_STRICT      = 1'b1;

  // Tokenizer states, one-hot
  typedef enum logic [TOK_STATE_COUNT-1:0] {
    ST_STANDARD         = 19'h00001,
    ST_DELIMITER        = 19'h00002,
    ST_DELIM_FIRST      = 19'h00004,
    ST_DELIM_SECOND     = 19'h00008,
    ST_DELIM_THIRD      = 19'h00010,
    ST_RECORD_SEP       = 19'h00020,
    ST_CARRIAGE_RETURN  = 19'h00040,
    ST_QUOTED           = 19'h00080,
    ST_UNQUOTED         = 19'h00100,
    ST_ESCAPE           = 19'h00200,
    ST_INVALID          = 19'h00400,
    ST_NOT_SET          = 19'h00800,
    ST_QUOTED_NEWLINE   = 19'h01000,
    ST_EMPTY_SPACE      = 19'h02000,
    ST_COMMENT          = 19'h04000,
    ST_STD_NEWLINE      = 19'h08000,
    ST_UNQUOTED_ESCAPE  = 19'h10000,
    ST_ESCAPED_RETURN   = 19'h20000,
    ST_MAYBE_QUOTED     = 19'h40000
  } tok_state_t;

  // Decoded dialect, derived from the configuration registers
  typedef struct packed {
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    logic [DLEN_W-1:0] len;
    logic [7:0] q;
    logic [7:0] e;
    logic [7:0] c;
    logic       crlf;
    logic       strict;
    logic       ue;
    logic       qe;
    logic       qnz;
    logic       cnz;
    logic       d0_not_sp;
    logic       unq_sp_ok;
    tok_state_t dt;
    tok_state_t crt;
  } dialect_t;

  // Skip flags of one byte
  typedef struct packed {
    logic standard;
    logic quoted;
    logic comment;
  } skip_flags_t;

  // Dense state number seen on the result port
  function automatic logic [STATE_CODE_W-1:0] state_code(input tok_state_t s);
    logic [STATE_CODE_W-1:0] code;
    unique case (s)
      ST_STANDARD:        code = 5'd0;
      ST_DELIMITER:       code = 5'd1;
      ST_DELIM_FIRST:     code = 5'd2;
      ST_DELIM_SECOND:    code = 5'd3;
      ST_DELIM_THIRD:     code = 5'd4;
      ST_RECORD_SEP:      code = 5'd5;
      ST_CARRIAGE_RETURN: code = 5'd6;
      ST_QUOTED:          code = 5'd7;
      ST_UNQUOTED:        code = 5'd8;
      ST_ESCAPE:          code = 5'd9;
      ST_INVALID:         code = 5'd10;
      ST_NOT_SET:         code = 5'd11;
      ST_QUOTED_NEWLINE:  code = 5'd12;
      ST_EMPTY_SPACE:     code = 5'd13;
      ST_COMMENT:         code = 5'd14;
      ST_STD_NEWLINE:     code = 5'd15;
      ST_UNQUOTED_ESCAPE: code = 5'd16;
      ST_ESCAPED_RETURN:  code = 5'd17;
      ST_MAYBE_QUOTED:    code = 5'd18;
      default:            code = 5'd11;
    endcase
    return code;
  endfunction

endpackage

### sv/csvt_cfg_regs.sv
// ----------------------------------------------------------------------------
// csvt_cfg_regs
// Dialect configuration registers and the decoded dialect they imply.
// ----------------------------------------------------------------------------
module csvt_cfg_regs
  import csvt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output dialect_t               dialect
);

  logic [CFG_DATA_W-1:0] delim_bytes_r;
  logic [DLEN_W-1:0]     delim_len_r;
  logic [7:0]            quote_r;
  logic [7:0]            escape_r;
  logic [7:0]            comment_r;
  logic                  crlf_r;
  logic                  strict_r;
  logic [DLEN_W-1:0]     eff_len;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= RST_DELIM_BYTES;
      delim_len_r   <= RST_DELIM_LEN;
      quote_r       <= RST_QUOTE;
      escape_r      <= RST_ESCAPE;
      comment_r     <= RST_COMMENT;
      crlf_r        <= RST_CRLF;
      strict_r      <= RST_STRICT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELIM_BYTES: delim_bytes_r <= cfg_wdata;
        CFG_DELIM_LEN:   delim_len_r   <= cfg_wdata[DLEN_W-1:0];
        CFG_QUOTE:       quote_r       <= cfg_wdata[7:0];
        CFG_ESCAPE:      escape_r      <= cfg_wdata[7:0];
        CFG_COMMENT:     comment_r     <= cfg_wdata[7:0];
        CFG_CRLF:        crlf_r        <= cfg_wdata[0];
        CFG_STRICT:      strict_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturate the delimiter length at the supported maximum
  assign eff_len = (delim_len_r > DLEN_W'(MAX_DELIMITER_BYTES)) ?
                   DLEN_W'(MAX_DELIMITER_BYTES) : delim_len_r;

  // Decode the dialect
  always_comb begin
    dialect.len       = eff_len;
    dialect.d0        = (eff_len != '0) ? delim_bytes_r[7:0] : CH_NUL;
    dialect.d1        = delim_bytes_r[15:8];
    dialect.d2        = delim_bytes_r[23:16];
    dialect.d3        = delim_bytes_r[31:24];
    dialect.q         = quote_r;
    dialect.e         = escape_r;
    dialect.c         = comment_r;
    dialect.crlf      = crlf_r;
    dialect.strict    = strict_r;
    dialect.qe        = (quote_r != escape_r) && (escape_r != CH_NUL);
    dialect.ue        = !strict_r && (quote_r != escape_r) && (escape_r != CH_NUL);
    dialect.qnz       = (quote_r != CH_NUL);
    dialect.cnz       = (comment_r != CH_NUL);
    dialect.d0_not_sp = (dialect.d0 != CH_SP);
    dialect.unq_sp_ok = (dialect.d0 != CH_SP) && (quote_r != CH_SP) &&
                        (escape_r != CH_SP) && (comment_r != CH_SP);
    dialect.dt        = (eff_len > DLEN_W'(1)) ? ST_DELIM_FIRST : ST_DELIMITER;
    dialect.crt       = crlf_r ? ST_CARRIAGE_RETURN : ST_RECORD_SEP;
  end

endmodule

### sv/csvt_next_state.sv
// ----------------------------------------------------------------------------
// csvt_next_state
// Transition and skip-flag logic: one byte and the current state in, the
// next state and the three skip flags out. Later rules override earlier ones.
// ----------------------------------------------------------------------------
module csvt_next_state
  import csvt_pkg::*;
(
  input  tok_state_t  state_in,
  input  logic [7:0]  byte_in,
  input  dialect_t    dialect,
  output tok_state_t  nxt_state,
  output skip_flags_t skip
);

  logic m_d0, m_d1, m_d2, m_d3, m_lf, m_cr, m_sp, m_q, m_e, m_c;

  // Byte comparators
  always_comb begin
    m_d0 = (byte_in == dialect.d0);
    m_d1 = (byte_in == dialect.d1);
    m_d2 = (byte_in == dialect.d2);
    m_d3 = (byte_in == dialect.d3);
    m_lf = (byte_in == CH_LF);
    m_cr = (byte_in == CH_CR);
    m_sp = (byte_in == CH_SP);
    m_q  = (byte_in == dialect.q);
    m_e  = (byte_in == dialect.e);
    m_c  = (byte_in == dialect.c);
  end

  // Skip flags
  always_comb begin
    skip.standard = !(m_d0 || m_lf || m_cr || m_c || (dialect.ue && m_e));
    skip.quoted   = !(m_q || m_e || m_lf || m_cr);
    skip.comment  = !(m_lf || m_cr);
  end

  // Transition rules, applied in order per state
  always_comb begin
    tok_state_t v;
    v = ST_STANDARD;
    unique case (state_in)
      ST_STANDARD, ST_INVALID, ST_STD_NEWLINE: begin
        v = ST_STANDARD;
        if (m_d0) v = dialect.dt;
        if (dialect.crlf) begin
          if (m_cr) v = ST_CARRIAGE_RETURN;
          if (m_lf) begin
            if (state_in == ST_STD_NEWLINE) v = ST_STANDARD;
            else v = dialect.strict ? ST_INVALID : ST_RECORD_SEP;
          end
        end else begin
          if (m_cr || m_lf) v = ST_RECORD_SEP;
        end
        if (dialect.cnz && m_c) v = ST_COMMENT;
        if (dialect.ue && m_e)  v = ST_UNQUOTED_ESCAPE;
      end
      ST_DELIMITER: begin
        v = ST_STANDARD;
        if (dialect.qnz && m_q)       v = ST_QUOTED;
        if (dialect.d0_not_sp && m_sp) v = ST_EMPTY_SPACE;
        if (m_d0) v = dialect.dt;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
        if (dialect.cnz && m_c) v = ST_COMMENT;
        if (dialect.ue && m_e)  v = ST_UNQUOTED_ESCAPE;
      end
      ST_DELIM_FIRST: begin
        v = ST_STANDARD;
        if (m_d0) v = dialect.dt;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
        if (dialect.len == DLEN_W'(2) && m_d1) v = ST_DELIMITER;
        if ((dialect.len == DLEN_W'(3) || dialect.len == DLEN_W'(4)) && m_d1) begin
          v = ST_DELIM_SECOND;
        end
      end
      ST_DELIM_SECOND: begin
        v = ST_STANDARD;
        if (m_d0) v = dialect.dt;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
        if (dialect.len == DLEN_W'(3)) begin
          if (dialect.d0 == dialect.d1 && m_d1) v = ST_DELIM_SECOND;
          if (m_d2) v = ST_DELIMITER;
        end
        if (dialect.len == DLEN_W'(4) && m_d2) v = ST_DELIM_THIRD;
      end
      ST_DELIM_THIRD: begin
        v = ST_STANDARD;
        if (m_d0) v = dialect.dt;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
        if (dialect.len == DLEN_W'(4)) begin
          if (dialect.d0 == dialect.d2 && m_d1) v = ST_DELIM_SECOND;
          if (dialect.d0 == dialect.d1 && dialect.d1 == dialect.d2 && m_d1) begin
            v = ST_DELIM_THIRD;
          end
          if (m_d3) v = ST_DELIMITER;
        end
      end
      ST_RECORD_SEP, ST_EMPTY_SPACE: begin
        v = ST_STANDARD;
        if (m_d0) v = dialect.dt;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
        if (dialect.qnz && m_q) v = ST_QUOTED;
        if (state_in == ST_RECORD_SEP && dialect.d0_not_sp && m_sp) begin
          v = ST_EMPTY_SPACE;
        end
        if (dialect.cnz && m_c) v = ST_COMMENT;
        if (dialect.ue && m_e)  v = ST_UNQUOTED_ESCAPE;
      end
      ST_CARRIAGE_RETURN: begin
        v = ST_STANDARD;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = ST_CARRIAGE_RETURN;
        if (dialect.qnz && m_q)        v = ST_QUOTED;
        if (dialect.d0_not_sp && m_sp) v = ST_EMPTY_SPACE;
        if (dialect.cnz && m_c)        v = ST_COMMENT;
        if (dialect.ue && m_e)         v = ST_UNQUOTED_ESCAPE;
      end
      ST_QUOTED: begin
        v = ST_QUOTED;
        if (m_q)          v = ST_UNQUOTED;
        if (m_lf || m_cr) v = ST_QUOTED_NEWLINE;
        if (dialect.qe && m_e) v = ST_ESCAPE;
      end
      ST_UNQUOTED: begin
        v = dialect.strict ? ST_INVALID : ST_UNQUOTED;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
        if (m_d0) v = dialect.dt;
        if (dialect.q == dialect.e && m_q) v = ST_QUOTED;
        if (!dialect.strict && m_q) begin
          v = (dialect.e == CH_NUL) ? ST_MAYBE_QUOTED : ST_QUOTED;
        end
        if (dialect.cnz && m_c)        v = ST_COMMENT;
        if (dialect.unq_sp_ok && m_sp) v = ST_UNQUOTED;
      end
      ST_QUOTED_NEWLINE: begin
        v = ST_QUOTED;
        if (m_q) v = ST_UNQUOTED;
        if (dialect.qe && m_e) v = ST_ESCAPE;
      end
      ST_ESCAPE: begin
        v = ST_QUOTED;
      end
      ST_COMMENT: begin
        v = ST_COMMENT;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
      end
      ST_UNQUOTED_ESCAPE: begin
        v = ST_STANDARD;
        if (dialect.ue && dialect.crlf && m_cr) v = ST_ESCAPED_RETURN;
      end
      ST_ESCAPED_RETURN: begin
        v = ST_STANDARD;
        if (dialect.ue) begin
          if (m_d0) v = ST_DELIMITER;
          if (m_cr) v = dialect.crt;
          if (dialect.cnz && m_c) v = ST_COMMENT;
          if (m_e)  v = ST_UNQUOTED_ESCAPE;
        end
      end
      ST_MAYBE_QUOTED: begin
        v = ST_QUOTED;
        if (m_q)  v = ST_MAYBE_QUOTED;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
        if (m_d0) v = dialect.dt;
      end
      default: begin
        // Not set, and any code outside the state set, steps as not set
        v = ST_STANDARD;
        if (m_d0) v = dialect.dt;
        if (m_lf) v = ST_RECORD_SEP;
        if (m_cr) v = dialect.crt;
        if (dialect.qnz && m_q)        v = ST_QUOTED;
        if (dialect.d0_not_sp && m_sp) v = ST_EMPTY_SPACE;
        if (dialect.cnz && m_c)        v = ST_COMMENT;
        if (dialect.ue && m_e)         v = ST_UNQUOTED_ESCAPE;
      end
    endcase
    nxt_state = v;
  end

endmodule

### sv/csv_dialect_tokenizer_fsm_core.sv
// ----------------------------------------------------------------------------
// csv_dialect_tokenizer_fsm_core
// Byte-at-a-time CSV tokenizer state machine with a configurable dialect.
// ----------------------------------------------------------------------------
// Each accepted byte yields one result: the tokenizer state after the byte
// plus skip flags for the standard, quoted and comment states. The block
// takes one byte per cycle while the result register is free or drained; an
// accepted byte is registered, runs through the transition comparators and
// its result is loaded into the result register, from which it transfers
// while out_ready holds. The tokenizer state register sits inside the loop
// through the comparators. The state resets to NOT_SET and is kept across
// configuration writes; a write is seen by the next byte to be stepped. A
// write must be made only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module csv_dialect_tokenizer_fsm_core
  import csvt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Byte input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_byte,
  // Result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATE_CODE_W-1:0] out_next_state,
  output logic                    out_skip_in_standard,
  output logic                    out_skip_in_quoted,
  output logic                    out_skip_in_comment,
  // Configuration
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  dialect_t    dialect;
  logic [7:0]  byte_r;
  logic        byte_vld_r;
  tok_state_t  state_r;
  tok_state_t  state_nxt;
  skip_flags_t skip_nxt;
  logic        out_valid_r;
  logic [STATE_CODE_W-1:0] out_state_r;
  skip_flags_t out_skip_r;
  logic        advance;
  logic        in_xfer;

  csvt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dialect   (dialect)
  );

  csvt_next_state u_ns (
    .state_in  (state_r),
    .byte_in   (byte_r),
    .dialect   (dialect),
    .nxt_state (state_nxt),
    .skip      (skip_nxt)
  );

  // Step the held byte when the result register is free or being drained
  assign advance  = byte_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !byte_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_ready) begin
      byte_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_byte;
    end
  end

  // Tokenizer state: advance once per stepped byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NOT_SET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state_r <= state_code(state_nxt);
      out_skip_r  <= skip_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_next_state       = out_state_r;
  assign out_skip_in_standard = out_skip_r.standard;
  assign out_skip_in_quoted   = out_skip_r.quoted;
  assign out_skip_in_comment  = out_skip_r.comment;

endmodule

### sv/csvt_checker.sv
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks for the CSV tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module csvt_checker
  import csvt_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STATE_CODE_W-1:0] out_next_state,
  input logic                    out_skip_in_standard,
  input logic                    out_skip_in_quoted,
  input logic                    out_skip_in_comment
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_state) &&
      $stable(out_skip_in_standard) && $stable(out_skip_in_quoted) &&
      $stable(out_skip_in_comment))
    else $error("result changed while stalled");

  // Reported state stays within the state set
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_next_state <= STATE_CODE_W'(TOK_STATE_COUNT - 1))
    else $error("result state out of range");

  // A line-end byte is special in every state group
  a_line_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_skip_in_comment |-> !out_skip_in_standard && !out_skip_in_quoted)
    else $error("line end marked skippable");

  // Come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind csv_dialect_tokenizer_fsm_core csvt_checker u_csvt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_next_state       (out_next_state),
  .out_skip_in_standard (out_skip_in_standard),
  .out_skip_in_quoted   (out_skip_in_quoted),
  .out_skip_in_comment  (out_skip_in_comment)
);

### tb/sv/tb_csv_dialect_tokenizer_fsm_core.sv
// ----------------------------------------------------------------------------
// tb_csv_dialect_tokenizer_fsm_core
// Self-checking bench for the byte-at-a-time CSV tokenizer state machine.
// ----------------------------------------------------------------------------
// A queue of text bytes feeds a valid/ready driver. Every byte transfer runs
// through a transition table that the bench rebuilds from its own copy of the
// dialect registers. The expected state and skip flags are then queued and
// compared with each result transfer. The run starts with a short directed
// text under the reset dialect. It then goes through a series of dialects,
// extremes among them, each fed with CSV-like text built from the dialect's
// own special bytes. Both sides idle at random, and once the receiver holds
// off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_csv_dialect_tokenizer_fsm_core;
  import csvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BYTES_PER_DIALECT = 144;
  localparam int unsigned LONG_HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT       = 600000;
  localparam int unsigned MAX_REPORTS       = 200;

  // Dense tokenizer state codes as seen on out_next_state
  typedef logic [STATE_CODE_W-1:0] tk_code_t;
  localparam tk_code_t TK_STANDARD     = 5'd0;
  localparam tk_code_t TK_DELIM        = 5'd1;
  localparam tk_code_t TK_DELIM_1ST    = 5'd2;
  localparam tk_code_t TK_DELIM_2ND    = 5'd3;
  localparam tk_code_t TK_DELIM_3RD    = 5'd4;
  localparam tk_code_t TK_RECORD_SEP   = 5'd5;
  localparam tk_code_t TK_CR           = 5'd6;
  localparam tk_code_t TK_QUOTED       = 5'd7;
  localparam tk_code_t TK_UNQUOTED     = 5'd8;
  localparam tk_code_t TK_ESCAPE       = 5'd9;
  localparam tk_code_t TK_INVALID      = 5'd10;
  localparam tk_code_t TK_NOT_SET      = 5'd11;
  localparam tk_code_t TK_QUOTED_NL    = 5'd12;
  localparam tk_code_t TK_EMPTY_SPACE  = 5'd13;
  localparam tk_code_t TK_COMMENT      = 5'd14;
  localparam tk_code_t TK_STD_NL       = 5'd15;
  localparam tk_code_t TK_UNQ_ESCAPE   = 5'd16;
  localparam tk_code_t TK_ESC_RETURN   = 5'd17;
  localparam tk_code_t TK_MAYBE_QUOTED = 5'd18;

  // Bytes used to build dialects and text
  localparam logic [7:0] BY_COMMA  = 8'h2C;
  localparam logic [7:0] BY_SEMI   = 8'h3B;
  localparam logic [7:0] BY_DQUOTE = 8'h22;
  localparam logic [7:0] BY_SQUOTE = 8'h27;
  localparam logic [7:0] BY_BSLASH = 8'h5C;
  localparam logic [7:0] BY_HASH   = 8'h23;
  localparam logic [7:0] BY_ONES   = 8'hFF;

  typedef struct packed {
    tk_code_t nstate;
    logic     skip_std;
    logic     skip_quo;
    logic     skip_com;
  } tok_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_byte = 8'h00;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATE_CODE_W-1:0] out_next_state;
  logic                    out_skip_in_standard;
  logic                    out_skip_in_quoted;
  logic                    out_skip_in_comment;
  logic                    cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = CFG_DELIM_BYTES;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  csv_dialect_tokenizer_fsm_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte              (in_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_next_state       (out_next_state),
    .out_skip_in_standard (out_skip_in_standard),
    .out_skip_in_quoted   (out_skip_in_quoted),
    .out_skip_in_comment  (out_skip_in_comment),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Bench-side dialect and tokenizer state
  logic [31:0] dlm_bytes;
  logic [2:0]  dlm_len;
  logic [7:0]  quote_ch;
  logic [7:0]  escape_ch;
  logic [7:0]  comment_ch;
  logic        crlf_on;
  logic        strict_on;
  tk_code_t    cur_tok;
  tk_code_t    trans [TOK_STATE_COUNT][256];

  logic [7:0]  text_q [$];
  tok_result_t token_q [$];

  int unsigned err_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned dialect_cnt = 0;
  int unsigned cycle_cnt = 0;

  int unsigned tx_level = 0;
  int unsigned rx_level = 0;
  int unsigned tx_gap_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned hold_left = 0;
  bit          long_hold_req = 1'b0;
  logic        in_xfer = 1'b0;

  function automatic int unsigned eff_delim_len();
    return (dlm_len > MAX_DELIMITER_BYTES) ? MAX_DELIMITER_BYTES : int'(dlm_len);
  endfunction

  function automatic logic [7:0] first_delim_byte();
    return (eff_delim_len() != 0) ? dlm_bytes[7:0] : CH_NUL;
  endfunction

  function automatic bit unq_escape_on();
    return !strict_on && (quote_ch != escape_ch) && (escape_ch != CH_NUL);
  endfunction

  function automatic void set_tr(tk_code_t s, logic [7:0] b, tk_code_t v);
    trans[s][b] = v;
  endfunction

  // Rebuild the transition table; later rules override earlier ones
  function automatic void rebuild_transitions();
    int unsigned len;
    logic [7:0]  d0, d1, d2, d3, q, e, c;
    bit          crlf, strict, ue, qe;
    tk_code_t    dt, crt, fill;
    tk_code_t    std_grp [3];
    tk_code_t    del_grp [4];
    len    = eff_delim_len();
    d0     = first_delim_byte();
    d1     = dlm_bytes[15:8];
    d2     = dlm_bytes[23:16];
    d3     = dlm_bytes[31:24];
    q      = quote_ch;
    e      = escape_ch;
    c      = comment_ch;
    crlf   = crlf_on;
    strict = strict_on;
    ue     = unq_escape_on();
    qe     = (q != e) && (e != CH_NUL);
    dt     = (len > 1) ? TK_DELIM_1ST : TK_DELIM;
    crt    = crlf ? TK_CR : TK_RECORD_SEP;
    std_grp = '{TK_STANDARD, TK_INVALID, TK_STD_NL};
    del_grp = '{TK_DELIM, TK_DELIM_1ST, TK_DELIM_2ND, TK_DELIM_3RD};

    // Background fill per state
    for (int s = 0; s < TOK_STATE_COUNT; s++) begin
      if (s == TK_MAYBE_QUOTED || s == TK_QUOTED || s == TK_QUOTED_NL || s == TK_ESCAPE)
        fill = TK_QUOTED;
      else if (s == TK_UNQUOTED)
        fill = strict ? TK_INVALID : TK_UNQUOTED;
      else if (s == TK_COMMENT)
        fill = TK_COMMENT;
      else
        fill = TK_STANDARD;
      for (int b = 0; b < 256; b++) trans[s][b] = fill;
    end

    // Unquoted field states
    foreach (std_grp[i]) begin
      set_tr(std_grp[i], d0, dt);
      if (crlf) begin
        set_tr(std_grp[i], CH_CR, TK_CR);
        if (std_grp[i] == TK_STD_NL)
          set_tr(std_grp[i], CH_LF, TK_STANDARD);
        else
          set_tr(std_grp[i], CH_LF, strict ? TK_INVALID : TK_RECORD_SEP);
      end else begin
        set_tr(std_grp[i], CH_CR, TK_RECORD_SEP);
        set_tr(std_grp[i], CH_LF, TK_RECORD_SEP);
      end
      if (c != CH_NUL) set_tr(std_grp[i], c, TK_COMMENT);
      if (ue) set_tr(std_grp[i], e, TK_UNQ_ESCAPE);
    end

    // Delimiter states, multi-byte delimiters included
    if (q != CH_NUL) set_tr(TK_DELIM, q, TK_QUOTED);
    if (d0 != CH_SP) set_tr(TK_DELIM, CH_SP, TK_EMPTY_SPACE);
    foreach (del_grp[i]) begin
      set_tr(del_grp[i], d0, dt);
      set_tr(del_grp[i], CH_LF, TK_RECORD_SEP);
      set_tr(del_grp[i], CH_CR, crt);
      if (c != CH_NUL) set_tr(TK_DELIM, c, TK_COMMENT);
    end
    case (len)
      2: set_tr(TK_DELIM_1ST, d1, TK_DELIM);
      3: begin
        if (d0 == d1) set_tr(TK_DELIM_2ND, d1, TK_DELIM_2ND);
        set_tr(TK_DELIM_1ST, d1, TK_DELIM_2ND);
        set_tr(TK_DELIM_2ND, d2, TK_DELIM);
      end
      4: begin
        if (d0 == d2) set_tr(TK_DELIM_3RD, d1, TK_DELIM_2ND);
        if (d0 == d1 && d1 == d2) set_tr(TK_DELIM_3RD, d1, TK_DELIM_3RD);
        set_tr(TK_DELIM_1ST, d1, TK_DELIM_2ND);
        set_tr(TK_DELIM_2ND, d2, TK_DELIM_3RD);
        set_tr(TK_DELIM_3RD, d3, TK_DELIM);
      end
      default: ;
    endcase
    if (ue) set_tr(TK_DELIM, e, TK_UNQ_ESCAPE);

    // Record separator
    set_tr(TK_RECORD_SEP, d0, dt);
    set_tr(TK_RECORD_SEP, CH_LF, TK_RECORD_SEP);
    set_tr(TK_RECORD_SEP, CH_CR, crt);
    if (q != CH_NUL) set_tr(TK_RECORD_SEP, q, TK_QUOTED);
    if (d0 != CH_SP) set_tr(TK_RECORD_SEP, CH_SP, TK_EMPTY_SPACE);
    if (c != CH_NUL) set_tr(TK_RECORD_SEP, c, TK_COMMENT);
    if (ue) set_tr(TK_RECORD_SEP, e, TK_UNQ_ESCAPE);

    // Carriage return
    set_tr(TK_CR, CH_LF, TK_RECORD_SEP);
    set_tr(TK_CR, CH_CR, TK_CR);
    if (q != CH_NUL) set_tr(TK_CR, q, TK_QUOTED);
    if (d0 != CH_SP) set_tr(TK_CR, CH_SP, TK_EMPTY_SPACE);
    if (c != CH_NUL) set_tr(TK_CR, c, TK_COMMENT);
    if (ue) set_tr(TK_CR, e, TK_UNQ_ESCAPE);

    // Quoted field
    set_tr(TK_QUOTED, q, TK_UNQUOTED);
    set_tr(TK_QUOTED, CH_LF, TK_QUOTED_NL);
    set_tr(TK_QUOTED, CH_CR, TK_QUOTED_NL);
    if (qe) set_tr(TK_QUOTED, e, TK_ESCAPE);

    // After a closing quote
    set_tr(TK_UNQUOTED, CH_LF, TK_RECORD_SEP);
    set_tr(TK_UNQUOTED, CH_CR, crt);
    set_tr(TK_UNQUOTED, d0, dt);
    if (q == e) set_tr(TK_UNQUOTED, q, TK_QUOTED);
    if (!strict) set_tr(TK_UNQUOTED, q, (e == CH_NUL) ? TK_MAYBE_QUOTED : TK_QUOTED);
    if (c != CH_NUL) set_tr(TK_UNQUOTED, c, TK_COMMENT);
    if (d0 != CH_SP && q != CH_SP && e != CH_SP && c != CH_SP)
      set_tr(TK_UNQUOTED, CH_SP, TK_UNQUOTED);

    // Start of text
    set_tr(TK_NOT_SET, d0, dt);
    set_tr(TK_NOT_SET, CH_LF, TK_RECORD_SEP);
    set_tr(TK_NOT_SET, CH_CR, crt);
    if (q != CH_NUL) set_tr(TK_NOT_SET, q, TK_QUOTED);
    if (d0 != CH_SP) set_tr(TK_NOT_SET, CH_SP, TK_EMPTY_SPACE);
    if (c != CH_NUL) set_tr(TK_NOT_SET, c, TK_COMMENT);
    if (ue) set_tr(TK_NOT_SET, e, TK_UNQ_ESCAPE);

    // Line end inside quotes
    set_tr(TK_QUOTED_NL, q, TK_UNQUOTED);
    if (qe) set_tr(TK_QUOTED_NL, e, TK_ESCAPE);

    // Leading space
    set_tr(TK_EMPTY_SPACE, d0, dt);
    set_tr(TK_EMPTY_SPACE, CH_LF, TK_RECORD_SEP);
    set_tr(TK_EMPTY_SPACE, CH_CR, crt);
    if (q != CH_NUL) set_tr(TK_EMPTY_SPACE, q, TK_QUOTED);
    if (c != CH_NUL) set_tr(TK_EMPTY_SPACE, c, TK_COMMENT);
    if (ue) set_tr(TK_EMPTY_SPACE, e, TK_UNQ_ESCAPE);

    // Comment runs to the line end
    set_tr(TK_COMMENT, CH_LF, TK_RECORD_SEP);
    set_tr(TK_COMMENT, CH_CR, crt);

    // Escapes outside quotes
    if (ue && crlf) set_tr(TK_UNQ_ESCAPE, CH_CR, TK_ESC_RETURN);
    if (ue) begin
      set_tr(TK_ESC_RETURN, d0, TK_DELIM);
      set_tr(TK_ESC_RETURN, CH_CR, crt);
      if (c != CH_NUL) set_tr(TK_ESC_RETURN, c, TK_COMMENT);
      set_tr(TK_ESC_RETURN, e, TK_UNQ_ESCAPE);
    end

    // Maybe quoted
    set_tr(TK_MAYBE_QUOTED, q, TK_MAYBE_QUOTED);
    set_tr(TK_MAYBE_QUOTED, CH_LF, TK_RECORD_SEP);
    set_tr(TK_MAYBE_QUOTED, CH_CR, crt);
    set_tr(TK_MAYBE_QUOTED, d0, dt);
  endfunction

  // Step the tokenizer by one byte and form its result
  function automatic tok_result_t step_tokenizer(logic [7:0] b);
    tok_result_t r;
    logic [7:0]  d0;
    d0 = first_delim_byte();
    cur_tok = trans[cur_tok][b];
    r.nstate   = cur_tok;
    r.skip_std = !(b == d0 || b == CH_LF || b == CH_CR || b == comment_ch ||
                   (unq_escape_on() && b == escape_ch));
    r.skip_quo = !(b == quote_ch || b == escape_ch || b == CH_LF || b == CH_CR);
    r.skip_com = !(b == CH_LF || b == CH_CR);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(int unsigned level);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (level == 0) return 0;
    if (level == 1) begin
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Sender: offer the head of the text queue, hold it until the transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_xfer) begin
      // hold the current byte
    end else if (tx_gap_left > 0) begin
      tx_gap_left--;
      in_valid <= 1'b0;
    end else if (text_q.size() > 0) begin
      in_valid    <= 1'b1;
      in_byte     <= text_q[0];
      tx_gap_left = pick_gap(tx_level);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD_CYCLES;
      out_ready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else begin
      rx_stall_left = pick_gap(rx_level);
      if (rx_stall_left == 0) begin
        out_ready <= 1'b1;
      end else begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end
    end
  end

  // Monitor: check result transfers, predict on byte transfers
  always @(posedge clk) begin
    tok_result_t want;
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result with no byte pending, expected none, got state %0d",
                     $time, out_next_state);
        end else begin
          want = token_q.pop_front();
          checked_cnt++;
          check_field("next_state", 32'(want.nstate), 32'(out_next_state));
          check_field("skip_in_standard", 32'(want.skip_std), 32'(out_skip_in_standard));
          check_field("skip_in_quoted", 32'(want.skip_quo), 32'(out_skip_in_quoted));
          check_field("skip_in_comment", 32'(want.skip_com), 32'(out_skip_in_comment));
        end
      end
      if (in_valid && in_ready) begin
        token_q.push_back(step_tokenizer(in_byte));
        void'(text_q.pop_front());
        bytes_sent++;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_cnt, token_q.size());
    $display("tb_csv_dialect_tokenizer_fsm_core failed");
    $finish;
  end

  // Wait until every byte has been sent and every result has come back
  task automatic wait_drained();
    while (text_q.size() != 0 || token_q.size() != 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DELIM_BYTES: dlm_bytes  = val;
      CFG_DELIM_LEN:   dlm_len    = val[2:0];
      CFG_QUOTE:       quote_ch   = val[7:0];
      CFG_ESCAPE:      escape_ch  = val[7:0];
      CFG_COMMENT:     comment_ch = val[7:0];
      CFG_CRLF:        crlf_on    = val[0];
      CFG_STRICT:      strict_on  = val[0];
      default: ;
    endcase
    rebuild_transitions();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void push_delim(bit partial);
    int unsigned len, n;
    len = eff_delim_len();
    if (len == 0) begin
      text_q.push_back(CH_NUL);
    end else begin
      n = partial ? $urandom_range(1, len) : len;
      for (int i = 0; i < n; i++) text_q.push_back(dlm_bytes[8*i +: 8]);
    end
  endfunction

  // CSV-like text from the current dialect's special bytes, with some noise
  function automatic void queue_text(int unsigned n);
    int unsigned start, r;
    start = text_q.size();
    while (text_q.size() - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 30)      text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      else if (r < 45) push_delim(1'b0);
      else if (r < 50) push_delim(1'b1);
      else if (r < 62) text_q.push_back(quote_ch);
      else if (r < 68) text_q.push_back(escape_ch);
      else if (r < 72) text_q.push_back(comment_ch);
      else if (r < 78) text_q.push_back(CH_SP);
      else if (r < 82) text_q.push_back(CH_CR);
      else if (r < 87) text_q.push_back(CH_LF);
      else if (r < 92) begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end else         text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic run_dialect(logic [31:0] db, logic [2:0] dl, logic [7:0] q, logic [7:0] e,
                             logic [7:0] c, logic crlf, logic strict,
                             int unsigned txl, int unsigned rxl, bit long_hold);
    wait_drained();
    write_reg(CFG_DELIM_BYTES, db);
    write_reg(CFG_DELIM_LEN, CFG_DATA_W'(dl));
    write_reg(CFG_QUOTE, CFG_DATA_W'(q));
    write_reg(CFG_ESCAPE, CFG_DATA_W'(e));
    write_reg(CFG_COMMENT, CFG_DATA_W'(c));
    write_reg(CFG_CRLF, CFG_DATA_W'(crlf));
    write_reg(CFG_STRICT, CFG_DATA_W'(strict));
    tx_level = txl;
    rx_level = rxl;
    dialect_cnt++;
    queue_text(BYTES_PER_DIALECT);
    if (long_hold) long_hold_req = 1'b1;
  endtask

  function automatic logic [7:0] pick_dialect_byte();
    case ($urandom_range(0, 11))
      0:       return CH_NUL;
      1:       return BY_COMMA;
      2:       return BY_SEMI;
      3:       return CH_SP;
      4:       return BY_DQUOTE;
      5:       return BY_SQUOTE;
      6:       return BY_BSLASH;
      7:       return BY_HASH;
      8:       return CH_CR;
      9:       return CH_LF;
      10:      return BY_ONES;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Main sequence
  initial begin
    logic [7:0] directed [24];
    logic [31:0] rdb;
    directed = '{8'h00, 8'hFF, 8'h61, 8'h2C, 8'h20, 8'h2C, 8'h22, 8'h78,
                 8'h22, 8'h22, 8'h0A, 8'h22, 8'h0D, 8'h22, 8'h2C, 8'h0D,
                 8'h0A, 8'h61, 8'h22, 8'h61, 8'h0A, 8'h20, 8'h2C, 8'h0A};

    // Reset dialect and state
    dlm_bytes  = RST_DELIM_BYTES;
    dlm_len    = RST_DELIM_LEN;
    quote_ch   = RST_QUOTE;
    escape_ch  = RST_ESCAPE;
    comment_ch = RST_COMMENT;
    crlf_on    = RST_CRLF;
    strict_on  = RST_STRICT;
    cur_tok    = TK_NOT_SET;
    rebuild_transitions();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed text under the reset dialect
    foreach (directed[i]) text_q.push_back(directed[i]);

    // Relaxed, escape and comment enabled, steady flow
    run_dialect({24'h0, BY_COMMA}, 3'd1, BY_DQUOTE, BY_BSLASH, BY_HASH, 1'b0, 1'b0,
                0, 0, 1'b0);
    // Two-byte delimiter, CR-LF, quote doubles as escape; long receiver hold
    run_dialect({16'h0, BY_SEMI, 8'h7C}, 3'd2, BY_DQUOTE, BY_DQUOTE, CH_NUL,
                1'b1, 1'b1, 0, 1, 1'b1);
    // Three-byte delimiter with repeated first byte, relaxed CR-LF
    run_dialect(32'h002D_3A3A, 3'd3, BY_SQUOTE, BY_BSLASH, CH_NUL, 1'b1, 1'b0,
                2, 2, 1'b0);
    // Four-byte delimiter, first three bytes equal, maybe-quoted path
    run_dialect(32'h5E7E_7E7E, 3'd4, BY_DQUOTE, CH_NUL, BY_HASH, 1'b0, 1'b0,
                1, 1, 1'b0);
    // Four-byte delimiter, first and third bytes equal
    run_dialect(32'h3B2C_3B2C, 3'd4, BY_DQUOTE, BY_BSLASH, CH_NUL, 1'b1, 1'b0,
                1, 2, 1'b0);
    // All-ones extremes, length saturates
    run_dialect(32'hFFFF_FFFF, 3'd7, BY_ONES, BY_ONES, BY_ONES, 1'b1, 1'b1,
                2, 1, 1'b0);
    // All zero: delimiter is byte zero, no quote, escape or comment
    run_dialect(32'h0000_0000, 3'd0, CH_NUL, CH_NUL, CH_NUL, 1'b0, 1'b0,
                1, 1, 1'b0);
    // Space as delimiter
    run_dialect({24'h0, CH_SP}, 3'd1, BY_DQUOTE, BY_BSLASH, BY_HASH, 1'b1, 1'b0,
                0, 2, 1'b0);

    // Random dialects from a pool of likely-special bytes
    repeat (3) begin
      rdb = {pick_dialect_byte(), pick_dialect_byte(), pick_dialect_byte(),
             pick_dialect_byte()};
      run_dialect(rdb, 3'($urandom_range(0, 7)), pick_dialect_byte(),
                  pick_dialect_byte(), pick_dialect_byte(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 2), $urandom_range(0, 2),
                  1'b0);
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("checked %0d results from %0d bytes over %0d dialects plus the reset one",
             checked_cnt, bytes_sent, dialect_cnt);
    $display("dialects spanned delimiter lengths 0 to 7, all-ones and zero special bytes");
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("tb_csv_dialect_tokenizer_fsm_core passed");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, token_q.size());
      $display("tb_csv_dialect_tokenizer_fsm_core failed");
    end
    $finish;
  end

endmodule
